// ===== hdl/ura_pkg.sv =====
// shared types, constants and helpers for the radix-to-ascii converter
`default_nettype none
package ura_pkg;

  localparam int VALUE_W   = 32;
  localparam int IDX_W     = $clog2(VALUE_W);
  localparam int CNT_W     = IDX_W + 1;
  localparam int DIGIT_W   = 6;
  localparam int CHAR_W    = 7;

  localparam logic [DIGIT_W-1:0] BASE_MIN   = 6'd2;
  localparam logic [DIGIT_W-1:0] BASE_MAX   = 6'd36;
  localparam logic [DIGIT_W-1:0] BASE_RESET = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_A    = 7'h61;
  localparam logic [DIGIT_W-1:0] DIGIT_NINE = 6'd9;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 6'd10;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } ura_state_t;

  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] dividend;
    logic [DIGIT_W-1:0] divisor;
  } ura_div_req_t;

  typedef struct packed {
    logic               done;
    logic [VALUE_W-1:0] quotient;
    logic [DIGIT_W-1:0] remainder;
  } ura_div_rsp_t;

  function automatic logic [DIGIT_W-1:0] clamp_base(input logic [DIGIT_W-1:0] b);
    logic [DIGIT_W-1:0] r;
    r = b;
    if (b < BASE_MIN) r = BASE_MIN;
    if (b > BASE_MAX) r = BASE_MAX;
    return r;
  endfunction

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d > DIGIT_NINE) begin
      c = CHAR_W'(d - DIGIT_TEN) + CHAR_A;
    end else begin
      c = CHAR_W'(d) + CHAR_ZERO;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/ura_div.sv =====
// iterative restoring divider, one quotient bit per cycle
`default_nettype none
module ura_div (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire ura_pkg::ura_div_req_t req,
  output ura_pkg::ura_div_rsp_t rsp
);

  logic [ura_pkg::VALUE_W-1:0] quo_r, quo_nxt;
  logic [ura_pkg::DIGIT_W-1:0] rem_r, rem_nxt;
  logic [ura_pkg::DIGIT_W-1:0] dvs_r, dvs_nxt;
  logic [ura_pkg::IDX_W-1:0]   cnt_r, cnt_nxt;
  logic                        run_r, run_nxt;
  logic                        done_r, done_nxt;
  logic [ura_pkg::DIGIT_W:0]   trial;

  always_comb begin
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    trial    = {rem_r, quo_r[ura_pkg::VALUE_W-1]};
    if (req.start) begin
      quo_nxt = req.dividend;
      rem_nxt = '0;
      dvs_nxt = req.divisor;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      // shift in next dividend bit, subtract when it fits
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = ura_pkg::DIGIT_W'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[ura_pkg::VALUE_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[ura_pkg::DIGIT_W-1:0];
        quo_nxt = {quo_r[ura_pkg::VALUE_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == ura_pkg::IDX_W'(ura_pkg::VALUE_W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done      = done_r;
  assign rsp.quotient  = quo_r;
  assign rsp.remainder = rem_r;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (rem_r < dvs_r))
    else $error("remainder not below divisor");

  a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !run_r)
    else $error("divider done while still running");

endmodule
`default_nettype wire

// ===== hdl/ura_digit_buf.sv =====
// digit store: remainders written least significant first, read back reversed
`default_nettype none
module ura_digit_buf (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [ura_pkg::IDX_W-1:0]   wr_idx,
  input  wire logic [ura_pkg::DIGIT_W-1:0] wr_data,
  input  wire logic                        rd_en,
  input  wire logic [ura_pkg::IDX_W-1:0]   rd_idx,
  output logic      [ura_pkg::DIGIT_W-1:0] rd_data_r
);

  logic [ura_pkg::DIGIT_W-1:0] mem [ura_pkg::VALUE_W];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/unsigned_to_radix_ascii_core.sv =====
// top level: converts one unsigned number into ascii digits of a configurable radix
// One number is taken when start is high and busy is low. Its digits are found by
// repeated division by the base in a shared bit-serial divider, least significant
// first, into a small digit store. The digits are then sent most significant first,
// one per cycle on out_valid, with out_last on the final one; the first character
// shows once the state has moved to the emit phase and the digit store read has
// been registered. A zero input gives one digit, '0'. The receiver cannot stall:
// every out_valid cycle is a transfer. Base writes on cfg_we are clamped to 2..36
// and must be made while busy is low; reset base is 10.
`default_nettype none
module unsigned_to_radix_ascii_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [ura_pkg::VALUE_W-1:0]  in_value,
  output logic                              out_valid,
  output logic      [ura_pkg::CHAR_W-1:0]   out_digit_char,
  output logic                              out_last,
  input  wire logic                         cfg_we,
  input  wire logic [ura_pkg::DIGIT_W-1:0]  cfg_wdata
);

  ura_pkg::ura_state_t          state_r, state_nxt;
  logic [ura_pkg::DIGIT_W-1:0]  base_r;
  logic [ura_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [ura_pkg::IDX_W-1:0]    emit_idx_r, emit_idx_nxt;
  logic                         out_valid_r, out_last_r;
  logic                         wr_en, rd_en;
  logic [ura_pkg::DIGIT_W-1:0]  rd_data;
  ura_pkg::ura_div_req_t        div_req;
  ura_pkg::ura_div_rsp_t        div_rsp;

  ura_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  ura_digit_buf u_buf (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_idx    (cnt_r[ura_pkg::IDX_W-1:0]),
    .wr_data   (div_rsp.remainder),
    .rd_en     (rd_en),
    .rd_idx    (emit_idx_r),
    .rd_data_r (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= ura_pkg::BASE_RESET;
    end else if (cfg_we) begin
      base_r <= ura_pkg::clamp_base(cfg_wdata);
    end
  end

  always_comb begin
    state_nxt        = state_r;
    cnt_nxt          = cnt_r;
    emit_idx_nxt     = emit_idx_r;
    wr_en            = 1'b0;
    rd_en            = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = in_value;
    div_req.divisor  = base_r;
    unique case (state_r)
      ura_pkg::ST_IDLE: begin
        if (start) begin
          div_req.start = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = ura_pkg::ST_DIV;
        end
      end
      ura_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          wr_en   = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
          if (div_rsp.quotient != '0) begin
            div_req.start    = 1'b1;
            div_req.dividend = div_rsp.quotient;
          end else begin
            // most significant digit is the one just written
            emit_idx_nxt = cnt_r[ura_pkg::IDX_W-1:0];
            state_nxt    = ura_pkg::ST_EMIT;
          end
        end
      end
      ura_pkg::ST_EMIT: begin
        rd_en = 1'b1;
        if (emit_idx_r == '0) begin
          state_nxt = ura_pkg::ST_IDLE;
        end else begin
          emit_idx_nxt = emit_idx_r - 1'b1;
        end
      end
      default: begin
        state_nxt = ura_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ura_pkg::ST_IDLE;
      cnt_r       <= '0;
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      emit_idx_r  <= emit_idx_nxt;
      // read data lands in the cycle after rd_en
      out_valid_r <= rd_en;
      out_last_r  <= rd_en && (emit_idx_r == '0);
    end
  end

  assign busy           = (state_r != ura_pkg::ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_last       = out_last_r;
  assign out_digit_char = ura_pkg::digit_to_ascii(rd_data);

  a_out_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(state_r == ura_pkg::ST_EMIT))
    else $error("result transfer without emit phase");

  a_digit_count: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ura_pkg::CNT_W'(ura_pkg::VALUE_W))
    else $error("digit count overflow");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ura_pkg::ST_DIV))
    else $error("divider finished outside divide phase");

  a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_last_r |-> (state_r == ura_pkg::ST_IDLE || state_r == ura_pkg::ST_DIV))
    else $error("last character while still emitting");

endmodule
`default_nettype wire

// ===== tb/sv/ura_checker.sv =====
// scoreboard for the radix-to-ascii converter: predicts each number's digits and checks them
`timescale 1ns / 1ps
`default_nettype none
module ura_checker (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic                         busy,
  input  wire logic [ura_pkg::VALUE_W-1:0]  in_value,
  input  wire logic                         out_valid,
  input  wire logic [ura_pkg::CHAR_W-1:0]   out_digit_char,
  input  wire logic                         out_last,
  input  wire logic                         cfg_we,
  input  wire logic [ura_pkg::DIGIT_W-1:0]  cfg_wdata,
  output int                                err_count,
  output int                                pending
);

  typedef struct packed {
    logic [ura_pkg::CHAR_W-1:0] ch;
    logic                       last;
  } digit_char_t;

  digit_char_t                  char_q[$];
  logic [ura_pkg::DIGIT_W-1:0]  radix;

  initial begin
    err_count = 0;
    pending   = 0;
    radix     = ura_pkg::BASE_RESET;
  end

  function automatic logic [ura_pkg::CHAR_W-1:0] char_of(
    input logic [ura_pkg::DIGIT_W-1:0] d);
    if (d > 6'd9) begin
      return ura_pkg::CHAR_W'(d - 6'd10) + ura_pkg::CHAR_A;
    end
    return ura_pkg::CHAR_W'(d) + ura_pkg::CHAR_ZERO;
  endfunction

  // digits come out of the division least significant first, queued most significant first
  task automatic queue_digits(input logic [ura_pkg::VALUE_W-1:0] v);
    logic [ura_pkg::VALUE_W-1:0] num;
    logic [ura_pkg::VALUE_W-1:0] wide_radix;
    logic [ura_pkg::DIGIT_W-1:0] digs[0:ura_pkg::VALUE_W];
    int                          n;
    digit_char_t                 c;
    num        = v;
    wide_radix = ura_pkg::VALUE_W'(radix);
    n          = 0;
    if (num == '0) begin
      digs[0] = '0;
      n       = 1;
    end else begin
      while (num != '0) begin
        digs[n] = ura_pkg::DIGIT_W'(num % wide_radix);
        n++;
        num = num / wide_radix;
      end
    end
    for (int k = n - 1; k >= 0; k--) begin
      c.ch   = char_of(digs[k]);
      c.last = (k == 0);
      char_q.push_back(c);
    end
  endtask

  always @(posedge clk) begin
    digit_char_t exp_c;
    if (!rst_n) begin
      radix = ura_pkg::BASE_RESET;
      char_q.delete();
    end else begin
      if (out_valid) begin
        if (char_q.size() == 0) begin
          $display("%0t: unexpected character %h last %b, nothing expected",
                   $time, out_digit_char, out_last);
          err_count++;
        end else begin
          exp_c = char_q.pop_front();
          if (out_digit_char !== exp_c.ch || out_last !== exp_c.last) begin
            $display("%0t: digit mismatch expected char %h last %b, got char %h last %b",
                     $time, exp_c.ch, exp_c.last, out_digit_char, out_last);
            err_count++;
          end
        end
      end
      if (start && !busy) begin
        queue_digits(in_value);
      end
      if (cfg_we) begin
        if (cfg_wdata < ura_pkg::BASE_MIN) begin
          radix = ura_pkg::BASE_MIN;
        end else if (cfg_wdata > ura_pkg::BASE_MAX) begin
          radix = ura_pkg::BASE_MAX;
        end else begin
          radix = cfg_wdata;
        end
      end
    end
    pending = char_q.size();
  end

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// testbench top for the radix-to-ascii converter: stimulus, base changes and verdict
`timescale 1ns / 1ps
`default_nettype none
module tb_top;

  localparam int CYCLE_LIMIT  = 4000000;
  localparam int PHASE_ITEMS  = 50;
  localparam int IDLE_PERCENT = 19;

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic [ura_pkg::VALUE_W-1:0]   in_value;
  logic                          out_valid;
  logic [ura_pkg::CHAR_W-1:0]    out_digit_char;
  logic                          out_last;
  logic                          cfg_we;
  logic [ura_pkg::DIGIT_W-1:0]   cfg_wdata;
  int                            err_count;
  int                            pending;
  int                            cycles;
  bit                            idle_on;
  int                            stim_base;

  unsigned_to_radix_ascii_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_digit_char (out_digit_char),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata)
  );

  ura_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_digit_char (out_digit_char),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .err_count      (err_count),
    .pending        (pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // busy only moves at the rising edge, so at the falling edge it tells whether
  // the coming edge will accept a transfer
  task automatic send_number(input logic [ura_pkg::VALUE_W-1:0] v);
    bit done;
    done = 1'b0;
    while (!done) begin
      @(negedge clk);
      if (!busy && !(idle_on && $urandom_range(99) < IDLE_PERCENT)) begin
        in_value <= v;
        start    <= 1'b1;
        done = 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  endtask

  task automatic wait_drained();
    bit done;
    done = 1'b0;
    while (!done) begin
      @(negedge clk);
      start <= 1'b0;
      if (pending == 0 && !busy) begin
        done = 1'b1;
      end
    end
  endtask

  task automatic write_base(input logic [ura_pkg::DIGIT_W-1:0] b);
    wait_drained();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= b;
    @(negedge clk);
    cfg_we    <= 1'b0;
    if (b < ura_pkg::BASE_MIN) begin
      stim_base = int'(ura_pkg::BASE_MIN);
    end else if (b > ura_pkg::BASE_MAX) begin
      stim_base = int'(ura_pkg::BASE_MAX);
    end else begin
      stim_base = int'(b);
    end
  endtask

  function automatic logic [ura_pkg::VALUE_W-1:0] pick_value();
    logic [63:0] p;
    int          k;
    int          kind;
    kind = $urandom_range(9);
    case (kind)
      4: begin
        return ura_pkg::VALUE_W'($urandom_range(0, 80));
      end
      5: begin
        case ($urandom_range(2))
          0: return '0;
          1: return '1;
          default: return ura_pkg::VALUE_W'(1);
        endcase
      end
      6: begin
        // near a power of the base, where the digit count changes
        p = 1;
        k = $urandom_range(1, 31);
        for (int i = 0; i < k && p * stim_base <= 64'hFFFF_FFFF; i++) begin
          p = p * stim_base;
        end
        case ($urandom_range(2))
          0: return ura_pkg::VALUE_W'(p - 1);
          1: return ura_pkg::VALUE_W'(p);
          default: return ura_pkg::VALUE_W'(p + 1);
        endcase
      end
      7: begin
        return $urandom() >> $urandom_range(31);
      end
      default: begin
        return $urandom();
      end
    endcase
  endfunction

  initial begin
    logic [ura_pkg::DIGIT_W-1:0] phase_base[8];
    rst_n     = 1'b0;
    start     = 1'b0;
    in_value  = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    idle_on   = 1'b1;
    stim_base = int'(ura_pkg::BASE_RESET);
    phase_base = '{6'd0, 6'd63, 6'd16, 6'd1, 6'd37, 6'd2, 6'd36, 6'd0};
    phase_base[7] = ura_pkg::DIGIT_W'($urandom_range(0, 63));
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    // reset base is decimal
    send_number(32'd0);
    send_number(32'd1);
    send_number(32'd9);
    send_number(32'd10);
    send_number(32'd99);
    send_number(32'd100);
    send_number(32'hFFFF_FFFF);
    send_number(32'h8000_0000);
    write_base(6'd36);
    send_number(32'd35);
    send_number(32'd36);
    send_number(32'd1295);
    send_number(32'd0);
    send_number(32'hFFFF_FFFF);
    write_base(6'd2);
    send_number(32'd0);
    send_number(32'd1);
    send_number(32'd2);
    send_number(32'hFFFF_FFFF);
    send_number(32'h8000_0000);
    write_base(6'd16);
    send_number(32'd255);
    send_number(32'd256);
    send_number(32'hDEAD_BEEF);
    write_base(6'd11);
    send_number(32'd10);

    for (int ph = 0; ph < 8; ph++) begin
      write_base(phase_base[ph]);
      idle_on = (ph != 3);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        send_number(pick_value());
        // sender pause until the block has drained, once in a while mid-phase
        if ($urandom_range(99) < 3) begin
          wait_drained();
        end
      end
    end

    wait_drained();
    repeat (40) @(negedge clk);
    if (err_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
